// ===== src/svl_pkg.sv =====
// shared types and codes for the sorted value list
package svl_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [3:0]         position;
  } svl_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } svl_out_t;

  typedef struct packed {
    logic               cmp_en;
    logic               ins_en;
    logic               rem_en;
    logic signed [31:0] value;
  } svl_ctl_t;

endpackage

// ===== src/svl_cell.sv =====
// one storage cell of the list: compares against the operand and shifts with its neighbors
module svl_cell (
  input  logic               clk,
  input  svl_pkg::svl_ctl_t  ctl,
  input  logic               cell_valid,
  input  logic               left_lt,
  input  logic signed [31:0] left_val,
  input  logic signed [31:0] right_val,
  output logic signed [31:0] val,
  output logic               lt,
  output logic               eq
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               lt_r;
  logic               eq_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && !lt_r) begin
      val_nxt = left_lt ? ctl.value : left_val;
    end else if (ctl.rem_en && !lt_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctl.cmp_en) begin
      lt_r <= cell_valid && (val_r < ctl.value);
      eq_r <= cell_valid && (val_r == ctl.value);
    end
  end

  assign val = val_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

// ===== src/sorted_value_list.sv =====
// sorted value list top level: command sequencer around a chain of compare-and-shift cells
//
//   channel   ports                          handshake
//   input     start, busy, in_item           taken when start is high and busy is low
//   result    out_valid, out_item            one-cycle strobe, one result per transaction
//
// each transaction runs through the accept edge, a compare step in which every cell
// compares its value with the operand, and an apply step in which the cells shift and the
// result is registered; busy is high during the compare and apply steps
// the chain of cells sets these steps: flags are registered before the list-wide match
// reduction steers the shift
// rst_n (synchronous) empties the list; stored values are not cleared
// the receiver cannot stall, so results leave as soon as they are made
module sorted_value_list #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  svl_pkg::svl_in_t  in_item,
  output logic              out_valid,
  output svl_pkg::svl_out_t out_item
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int RDN = (CAPACITY < 16) ? CAPACITY : 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t             state_r;
  svl_pkg::svl_in_t   op_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  svl_pkg::svl_out_t  out_r;
  svl_pkg::svl_out_t  out_nxt;
  logic               out_valid_r;

  svl_pkg::svl_ctl_t  ctl;
  logic signed [31:0] vals   [CAPACITY];
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;
  logic               found;
  logic               full;
  logic signed [31:0] rd_val;

  assign busy  = (state_r != S_IDLE);
  assign found = |eq_w;
  assign full  = (count_r == CW'(CAPACITY));

  always_comb begin
    ctl.cmp_en = (state_r == S_CMP);
    ctl.ins_en = (state_r == S_APPLY) && (op_r.cmd == svl_pkg::CMD_INSERT) && !full;
    ctl.rem_en = (state_r == S_APPLY) && (op_r.cmd == svl_pkg::CMD_REMOVE) && found;
    ctl.value  = op_r.value;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic               left_lt;
      logic signed [31:0] left_val;
      logic signed [31:0] right_val;
      if (g == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_val = op_r.value;
      end else begin : g_mid
        assign left_lt  = lt_w[g-1];
        assign left_val = vals[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_val = vals[g];
      end else begin : g_inner
        assign right_val = vals[g+1];
      end
      svl_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .cell_valid (count_r > CW'(g)),
        .left_lt    (left_lt),
        .left_val   (left_val),
        .right_val  (right_val),
        .val        (vals[g]),
        .lt         (lt_w[g]),
        .eq         (eq_w[g])
      );
    end
  endgenerate

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RDN; i++) begin
      if (op_r.position == 4'(i)) begin
        rd_val = vals[i];
      end
    end
  end

  always_comb begin
    count_nxt          = count_r;
    out_nxt.status     = svl_pkg::ST_OK;
    out_nxt.read_value = '0;
    case (op_r.cmd)
      svl_pkg::CMD_INSERT: begin
        if (full) begin
          out_nxt.status = svl_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      svl_pkg::CMD_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CW'(1);
        end else begin
          out_nxt.status = svl_pkg::ST_NOT_FOUND;
        end
      end
      svl_pkg::CMD_READ: begin
        if (int'(op_r.position) < int'(count_r)) begin
          out_nxt.read_value = rd_val;
        end else begin
          out_nxt.status = svl_pkg::ST_BAD_POS;
        end
      end
      default: begin
      end
    endcase
    out_nxt.entry_count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_item;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          count_r     <= count_nxt;
          out_r       <= out_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(state_r == S_APPLY))
    else $error("result strobe outside the apply step");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == svl_pkg::ST_FULL |-> full)
    else $error("full status with room in the list");

endmodule

// ===== tb/sorted_value_list_tb.sv =====
// self-checking testbench for the sorted value list: directed and random commands
module sorted_value_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  svl_pkg::svl_in_t  in_item;
  logic              out_valid;
  svl_pkg::svl_out_t out_item;

  logic signed [31:0] list_vals [CAPACITY];
  int                 list_count;
  svl_pkg::svl_out_t  expected_results [$];
  int                 error_count;
  int                 idle_pct;
  int                 cycle_count;

  sorted_value_list #(.CAPACITY(CAPACITY)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_value_list regression: fail");
    $finish;
  end

  function automatic svl_pkg::svl_out_t predict_list_step(svl_pkg::svl_in_t t);
    svl_pkg::svl_out_t  r;
    int                 i;
    int                 k;
    logic signed [31:0] v;
    v = t.value;
    r.status = svl_pkg::ST_OK;
    r.read_value = '0;
    case (t.cmd)
      svl_pkg::CMD_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = svl_pkg::ST_FULL;
        end else begin
          i = 0;
          while (i < list_count && list_vals[i] < v) i++;
          for (k = list_count; k > i; k--) list_vals[k] = list_vals[k-1];
          list_vals[i] = v;
          list_count++;
        end
      end
      svl_pkg::CMD_REMOVE: begin
        r.status = svl_pkg::ST_NOT_FOUND;
        for (i = 0; i < list_count; i++) begin
          if (r.status == svl_pkg::ST_NOT_FOUND && list_vals[i] == v) begin
            for (k = i; k + 1 < list_count; k++) list_vals[k] = list_vals[k+1];
            list_count--;
            r.status = svl_pkg::ST_OK;
          end
        end
      end
      svl_pkg::CMD_READ: begin
        if (int'(t.position) < list_count) r.read_value = list_vals[t.position];
        else r.status = svl_pkg::ST_BAD_POS;
      end
      default: ;
    endcase
    r.entry_count = list_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 50) begin
      $display("%0t ns mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    svl_pkg::svl_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction pending", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.read_value !== want.read_value)
          report_mismatch("read_value", out_item.read_value, want.read_value);
        if (out_item.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_item.entry_count, want.entry_count);
      end
    end
  end

  task automatic send_command(input logic [1:0] cmd, input logic signed [31:0] value,
                              input logic [3:0] position);
    svl_pkg::svl_in_t t;
    int               gap;
    bit               taken;
    t.cmd = cmd;
    t.value = value;
    t.position = position;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_item = t;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    expected_results.push_back(predict_list_step(t));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_value();
    int r;
    int near_zero;
    r = $urandom_range(0, 99);
    near_zero = $urandom_range(0, 15);
    if (r < 50) return near_zero - 8;
    if (r < 60) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  task automatic test_empty_list();
    send_command(svl_pkg::CMD_REMOVE, 32'sd5, 4'd0);
    send_command(svl_pkg::CMD_READ, 32'sd0, 4'd0);
    send_command(CMD_UNUSED, -32'sd1, 4'd15);
  endtask

  task automatic test_fill_to_capacity();
    logic signed [31:0] fill [16];
    fill = '{VAL_MAX, VAL_MIN, 0, -1, 1, 7, 7, 7, -8, VAL_MAX, VAL_MIN, 100, -100, 3, 3, 42};
    foreach (fill[i]) send_command(svl_pkg::CMD_INSERT, fill[i], 4'(i));
    send_command(svl_pkg::CMD_INSERT, 32'sd9, 4'd0);
    send_command(svl_pkg::CMD_READ, 32'sd0, 4'd0);
    send_command(svl_pkg::CMD_READ, 32'sd0, 4'd15);
  endtask

  task automatic test_remove_and_read();
    send_command(svl_pkg::CMD_REMOVE, 32'sd1234, 4'd0);
    send_command(svl_pkg::CMD_REMOVE, 32'sd7, 4'd0);
    send_command(svl_pkg::CMD_REMOVE, VAL_MIN, 4'd0);
    send_command(svl_pkg::CMD_READ, 32'sd0, 4'd14);
    send_command(svl_pkg::CMD_READ, 32'sd0, 4'd12);
  endtask

  task automatic test_random_traffic(input int n_items, input int sender_idle_pct);
    int                 r;
    int                 insert_pct;
    logic [1:0]         cmd;
    logic signed [31:0] value;
    idle_pct = sender_idle_pct;
    for (int n = 0; n < n_items; n++) begin
      insert_pct = ((n / 64) % 2) ? 25 : 55;
      r = $urandom_range(0, 99);
      if (r < insert_pct) cmd = svl_pkg::CMD_INSERT;
      else if (r < 80) cmd = svl_pkg::CMD_REMOVE;
      else if (r < 97) cmd = svl_pkg::CMD_READ;
      else cmd = CMD_UNUSED;
      value = random_value();
      if (cmd == svl_pkg::CMD_REMOVE && list_count > 0 && $urandom_range(0, 99) < 60)
        value = list_vals[$urandom_range(0, list_count - 1)];
      send_command(cmd, value, 4'($urandom_range(0, 15)));
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    list_count = 0;
    error_count = 0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_remove_and_read();
    wait_results_drained();

    test_random_traffic(500, 0);
    test_random_traffic(500, 53);
    wait_results_drained();
    test_random_traffic(500, 0);
    test_random_traffic(500, 36);
    wait_results_drained();

    if (error_count == 0) begin
      $display("sorted_value_list regression: pass");
    end else begin
      $display("sorted_value_list regression: fail");
    end
    $finish;
  end

endmodule
